// ----- rtl/core/sphere_overlap_placement_table_top_assert.svh -----
// Assertion macros used by the sphere placement table RTL.
`ifndef SPHERE_OVERLAP_PLACEMENT_TABLE_TOP_ASSERT_SVH
`define SPHERE_OVERLAP_PLACEMENT_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked by clk_i, off while rst_ni is low.
`define SOPT_ASSERT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("sopt: assertion failed");
// Next-cycle implication, clocked by clk_i, off while rst_ni is low.
`define SOPT_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("sopt: assertion failed");
`else
`define SOPT_ASSERT(lbl, ant, con)
`define SOPT_ASSERT_NEXT(lbl, ant, con)
`endif

`endif

// ----- rtl/core/sopt_pkg.sv -----
// Shared types and codes for the sphere placement table.
package sopt_pkg;

  // Candidate opcodes carried on tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TEST   = 1'b1;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } sopt_state_e;

  // Per-cell controls from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Status from the compare pipeline
  typedef struct packed {
    logic busy;
    logic hit;
  } cmp_stat_t;

endpackage

// ----- rtl/core/sopt_cell.sv -----
// One storage cell of the rotating sphere ring.
module sopt_cell #(
  parameter int ENT_W = 79
) (
  input  logic                clk_i,
  input  sopt_pkg::cell_ctrl_t ctrl_i,
  input  logic [ENT_W-1:0]    nbr_i,
  input  logic [ENT_W-1:0]    load_i,
  output logic [ENT_W-1:0]    ent_o
);

  logic [ENT_W-1:0] ent_q;

  // Load a new sphere, or take the neighbor's entry as the ring turns
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ent_q <= load_i;
    end else if (ctrl_i.shift) begin
      ent_q <= nbr_i;
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- rtl/core/sopt_cmp.sv -----
// Four-stage exact overlap test of a candidate against one stored sphere.
module sopt_cmp #(
  parameter int COORD_BITS = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [4*COORD_BITS-2:0]   qry_i,
  input  logic [4*COORD_BITS-2:0]   ent_i,
  output sopt_pkg::cmp_stat_t       stat_o
);

  localparam int C     = COORD_BITS;
  localparam int RAD_W = C - 1;
  localparam int SQ_W  = 2 * C;

  logic [2:0][C-1:0] q_axis, e_axis;
  logic [2:0][C-1:0] mag_d, mag_q;
  logic [C-1:0]      rs_d, rs_q;
  logic [2:0][SQ_W-1:0] sq_q;
  logic [SQ_W-1:0]   rs2_q, rs2b_q, sq2_q;
  logic [SQ_W:0]     s01_q;
  logic [SQ_W+1:0]   d2;
  logic              hit_d, hit_q;
  logic              v1_q, v2_q, v3_q, v4_q;

  // Unpack centers: x, y, z above the radius
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      q_axis[a] = qry_i[RAD_W + a*C +: C];
      e_axis[a] = ent_i[RAD_W + a*C +: C];
    end
  end

  // Stage 1 logic: absolute center differences and radius sum
  always_comb begin
    logic signed [C:0] diff;
    for (int a = 0; a < 3; a++) begin
      diff = $signed({q_axis[a][C-1], q_axis[a]}) - $signed({e_axis[a][C-1], e_axis[a]});
      if (diff[C]) begin
        diff = -diff;
      end
      mag_d[a] = diff[C-1:0];
    end
    rs_d = {1'b0, qry_i[RAD_W-1:0]} + {1'b0, ent_i[RAD_W-1:0]};
  end

  // Stage 4 logic: full squared distance against squared radius sum
  assign d2    = {1'b0, s01_q} + {2'b00, sq2_q};
  assign hit_d = {2'b00, rs2b_q} > d2;

  // Valid bits of the four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rs_q   <= rs_d;
    for (int a = 0; a < 3; a++) begin
      sq_q[a] <= mag_q[a] * mag_q[a];
    end
    rs2_q  <= rs_q * rs_q;
    s01_q  <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
    sq2_q  <= sq_q[2];
    rs2b_q <= rs2_q;
    hit_q  <= hit_d;
  end

  assign stat_o.busy = v1_q | v2_q | v3_q | v4_q;
  assign stat_o.hit  = v4_q & hit_q;

endmodule

// ----- rtl/core/sphere_overlap_placement_table_top.sv -----
// Sphere placement table: rotating ring of stored spheres with one overlap tester.
//
//  channel   | dir | tdata fields (lsb first)                  | tuser
//  s_axis    | in  | query_radius, query_x, query_y, query_z   | opcode
//  m_axis    | out | overlap_found, was_inserted, table_full,  | -
//            |     | entry_count                               |
//
// Opcode 0 or an empty table goes from IDLE straight to FINISH; else SCAN runs the
// ring through its single turn (one sphere per cycle) and DRAIN waits while the last
// stored spheres are still in the four-stage compare unit, before FINISH.
// Reset clears the entry count, sequencer and output valid; cell contents stay
// undefined until written and no clearing pass runs.
// IDLE takes a candidate even while a result waits; its result holds in FINISH.
`include "sphere_overlap_placement_table_top_assert.svh"

module sphere_overlap_placement_table_top #(
  parameter int MAX_SPHERES = 1024,
  parameter int COORD_BITS  = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  // query_radius, query_x, query_y, query_z
  input  logic [((4*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // overlap_found, was_inserted, table_full, entry_count
  output logic [((3+$clog2(MAX_SPHERES+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);

  localparam int ENT_W = 4 * COORD_BITS - 1;
  localparam int OUT_W = ((3 + $clog2(MAX_SPHERES + 1) + 7) / 8) * 8;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);
  localparam int IDX_W = $clog2(MAX_SPHERES);

  sopt_pkg::sopt_state_e state_q, state_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             hit_q, hit_d;
  logic [ENT_W-1:0] qry_q;
  logic             shift_en, cmp_vld, fin, ins_w, full_w, ins_en, s_fire;
  logic             m_valid_q, ovl_q, ins_q, full_q;
  logic [CNT_W-1:0] cnt_out_q;
  sopt_pkg::cmp_stat_t cmp_stat;
  logic [ENT_W-1:0] ent [MAX_SPHERES];

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign ins_w  = !hit_q && (count_q < CNT_W'(MAX_SPHERES));
  assign full_w = !hit_q && (count_q == CNT_W'(MAX_SPHERES));
  assign ins_en = fin && ins_w;

  // Ring of cells; the head feeds both the tester and the tail
  for (genvar i = 0; i < MAX_SPHERES; i++) begin : g_cell
    sopt_pkg::cell_ctrl_t ctrl;
    logic [ENT_W-1:0]     nbr;
    assign ctrl.shift = shift_en;
    assign ctrl.load  = ins_en && (count_q[IDX_W-1:0] == IDX_W'(i));
    if (i == MAX_SPHERES - 1) begin : g_tail
      assign nbr = ent[0];
    end else begin : g_body
      assign nbr = ent[i+1];
    end
    sopt_cell #(.ENT_W(ENT_W)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .nbr_i  (nbr),
      .load_i (qry_q),
      .ent_o  (ent[i])
    );
  end

  // Overlap tester at the ring head
  sopt_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (cmp_vld),
    .qry_i  (qry_q),
    .ent_i  (ent[0]),
    .stat_o (cmp_stat)
  );

  // Sequencer: next state and controls
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    hit_d      = hit_q | cmp_stat.hit;
    s_axis_tready = 1'b0;
    shift_en   = 1'b0;
    cmp_vld    = 1'b0;
    fin        = 1'b0;
    unique case (state_q)
      sopt_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          hit_d      = 1'b0;
          scan_idx_d = '0;
          if (s_axis_tuser == sopt_pkg::OP_TEST && count_q != '0) begin
            state_d = sopt_pkg::ST_SCAN;
          end else begin
            state_d = sopt_pkg::ST_FINISH;
          end
        end
      end
      sopt_pkg::ST_SCAN: begin
        shift_en = 1'b1;
        cmp_vld  = CNT_W'(scan_idx_q) < count_q;
        if (scan_idx_q == IDX_W'(MAX_SPHERES - 1)) begin
          state_d = sopt_pkg::ST_DRAIN;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      sopt_pkg::ST_DRAIN: begin
        if (!cmp_stat.busy) begin
          state_d = sopt_pkg::ST_FINISH;
        end
      end
      sopt_pkg::ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          fin     = 1'b1;
          state_d = sopt_pkg::ST_IDLE;
        end
      end
      default: state_d = sopt_pkg::ST_IDLE;
    endcase
  end

  assign count_d = count_q + CNT_W'(ins_en);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sopt_pkg::ST_IDLE;
      scan_idx_q <= '0;
      count_q    <= '0;
      hit_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      count_q    <= count_d;
      hit_q      <= hit_d;
      if (fin) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Candidate and result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      qry_q <= s_axis_tdata[ENT_W-1:0];
    end
    if (fin) begin
      ovl_q     <= hit_q;
      ins_q     <= ins_w;
      full_q    <= full_w;
      cnt_out_q <= count_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({cnt_out_q, full_q, ins_q, ovl_q});

  `SOPT_ASSERT(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_SPHERES))
  `SOPT_ASSERT(a_flags_excl, m_valid_q,
               !(ovl_q && ins_q) && !(ins_q && full_q) && !(ovl_q && full_q))
  `SOPT_ASSERT_NEXT(a_insert_count, ins_en, count_q == $past(count_q) + 1'b1)
  `SOPT_ASSERT_NEXT(a_scan_step,
                    state_q == sopt_pkg::ST_SCAN && scan_idx_q != IDX_W'(MAX_SPHERES - 1),
                    state_q == sopt_pkg::ST_SCAN && scan_idx_q == $past(scan_idx_q) + 1'b1)
  `SOPT_ASSERT_NEXT(a_insert_no_test,
                    s_fire && s_axis_tuser == sopt_pkg::OP_INSERT,
                    state_q == sopt_pkg::ST_FINISH && !hit_q)

endmodule
